>>> rtl/rmq_pkg.sv
// Shared constants and types for the rotation matrix to quaternion pipeline.
`default_nettype none
package rmq_pkg;

  localparam int MW          = 16;
  localparam int CW          = 19;
  localparam int MAGW        = 17;
  localparam int SQW         = 2 * MAGW;
  localparam int NW          = 36;
  localparam int VW          = 64;
  localparam int ROOTW       = VW / 2;
  localparam int REMW        = ROOTW + 2;
  localparam int DW          = ROOTW + 1;
  localparam int QW          = 15;
  localparam int NUMW        = MAGW + 29 + 1;
  localparam int SQRT_STEPS  = ROOTW;
  localparam int DIV_STEPS   = QW;
  localparam int LATENCY     = 4 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam logic [QW-1:0] UNIT_Q14 = 15'd16384;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_M00   = 2'd1,
    BR_M11   = 2'd2,
    BR_M22   = 2'd3
  } branch_t;

  typedef struct packed {
    logic                 valid;
    logic                 deg;
    branch_t              branch;
    logic [3:0]           neg;
    logic [3:0][MAGW-1:0] mag;
  } side_a_t;

  typedef struct packed {
    logic       valid;
    logic       deg;
    branch_t    branch;
    logic [3:0] neg;
  } side_b_t;

endpackage
`default_nettype wire

>>> rtl/rmq_sqrt_cell.sv
// One cell of the square root chain: resolves one root bit per cycle.
`default_nettype none
module rmq_sqrt_cell import rmq_pkg::*; (
  input  wire logic             clk,
  input  wire logic [VW-1:0]    v_i,
  input  wire logic [REMW-1:0]  rem_i,
  input  wire logic [ROOTW-1:0] root_i,
  output logic      [VW-1:0]    v_r,
  output logic      [REMW-1:0]  rem_r,
  output logic      [ROOTW-1:0] root_r
);

  logic [REMW+1:0] t;
  logic [REMW+1:0] trial;
  logic            ge;
  logic [REMW-1:0] rem_nxt;

  always_comb begin
    t       = {rem_i, v_i[VW-1 -: 2]};
    trial   = {2'b00, root_i, 2'b01};
    ge      = (t >= trial);
    rem_nxt = ge ? REMW'(t - trial) : REMW'(t);
  end

  always_ff @(posedge clk) begin
    v_r    <= {v_i[VW-3:0], 2'b00};
    rem_r  <= rem_nxt;
    root_r <= {root_i[ROOTW-2:0], ge};
  end

endmodule
`default_nettype wire

>>> rtl/rmq_div_cell.sv
// One cell of the divider chain: resolves one quotient bit per cycle.
`default_nettype none
module rmq_div_cell import rmq_pkg::*; (
  input  wire logic          clk,
  input  wire logic [DW-1:0] p_i,
  input  wire logic [QW-1:0] lo_i,
  input  wire logic [DW-1:0] d_i,
  input  wire logic [QW-1:0] q_i,
  input  wire logic          ovf_i,
  output logic      [DW-1:0] p_r,
  output logic      [QW-1:0] lo_r,
  output logic      [DW-1:0] d_r,
  output logic      [QW-1:0] q_r,
  output logic               ovf_r
);

  logic [DW:0] t;
  logic        ge;

  always_comb begin
    t  = {p_i, lo_i[QW-1]};
    ge = (t >= {1'b0, d_i});
  end

  always_ff @(posedge clk) begin
    p_r   <= ge ? DW'(t - {1'b0, d_i}) : DW'(t);
    lo_r  <= {lo_i[QW-2:0], 1'b0};
    d_r   <= d_i;
    q_r   <= {q_i[QW-2:0], ge};
    ovf_r <= ovf_i;
  end

endmodule
`default_nettype wire

>>> rtl/rotation_matrix_to_quaternion.sv
// Top level: pipelined Shepperd conversion of a Q2.14 rotation matrix to a unit quaternion.
//
// Channel  Direction  Handshake           Payload
// in       input      start / busy        in_m00 .. in_m22
// out      output     out_valid strobe    out_quat_x/y/z/w, out_branch_taken, out_degenerate
//
// One request is accepted in every cycle; busy stays low.
// Each result passes through the 32-cell square root chain and the 15-cell divider chain,
// plus six stages of setup and output, before it is registered on the outputs.
// Synchronous active-low reset clears the input valid bit, the side-band stages and
// the output strobe.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic signed [MW-1:0] in_m00,
  input  wire logic signed [MW-1:0] in_m01,
  input  wire logic signed [MW-1:0] in_m02,
  input  wire logic signed [MW-1:0] in_m10,
  input  wire logic signed [MW-1:0] in_m11,
  input  wire logic signed [MW-1:0] in_m12,
  input  wire logic signed [MW-1:0] in_m20,
  input  wire logic signed [MW-1:0] in_m21,
  input  wire logic signed [MW-1:0] in_m22,
  output logic                      out_valid,
  output logic signed [MW-1:0]      out_quat_x,
  output logic signed [MW-1:0]      out_quat_y,
  output logic signed [MW-1:0]      out_quat_z,
  output logic signed [MW-1:0]      out_quat_w,
  output logic        [1:0]         out_branch_taken,
  output logic                      out_degenerate
);

  assign busy = 1'b0;

  logic                 v0_r;
  logic signed [CW-1:0] m_r [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
    m_r[0] <= CW'(in_m00);
    m_r[1] <= CW'(in_m01);
    m_r[2] <= CW'(in_m02);
    m_r[3] <= CW'(in_m10);
    m_r[4] <= CW'(in_m11);
    m_r[5] <= CW'(in_m12);
    m_r[6] <= CW'(in_m20);
    m_r[7] <= CW'(in_m21);
    m_r[8] <= CW'(in_m22);
  end

  logic signed [CW-1:0] c [4];
  logic signed [CW-1:0] rad;
  logic signed [CW-1:0] unit_s;
  branch_t              br;
  side_a_t              s1_nxt;

  always_comb begin
    unit_s = CW'(signed'({1'b0, UNIT_Q14}));
    if (m_r[0] + m_r[4] + m_r[8] > 0) begin
      br   = BR_TRACE;
      rad  = unit_s + m_r[0] + m_r[4] + m_r[8];
      c[0] = m_r[7] - m_r[5];
      c[1] = m_r[2] - m_r[6];
      c[2] = m_r[3] - m_r[1];
      c[3] = rad;
    end else if (m_r[0] > m_r[4] && m_r[0] > m_r[8]) begin
      br   = BR_M00;
      rad  = unit_s + m_r[0] - m_r[4] - m_r[8];
      c[0] = rad;
      c[1] = m_r[1] + m_r[3];
      c[2] = m_r[2] + m_r[6];
      c[3] = m_r[7] - m_r[5];
    end else if (m_r[4] > m_r[8]) begin
      br   = BR_M11;
      rad  = unit_s + m_r[4] - m_r[0] - m_r[8];
      c[0] = m_r[1] + m_r[3];
      c[1] = rad;
      c[2] = m_r[5] + m_r[7];
      c[3] = m_r[2] - m_r[6];
    end else begin
      br   = BR_M22;
      rad  = unit_s + m_r[8] - m_r[0] - m_r[4];
      c[0] = m_r[2] + m_r[6];
      c[1] = m_r[5] + m_r[7];
      c[2] = rad;
      c[3] = m_r[3] - m_r[1];
    end
    s1_nxt.valid  = v0_r;
    s1_nxt.deg    = (rad <= 0);
    s1_nxt.branch = br;
    for (int i = 0; i < 4; i++) begin
      s1_nxt.neg[i] = c[i][CW-1];
      s1_nxt.mag[i] = c[i][CW-1] ? MAGW'(-c[i]) : MAGW'(c[i]);
    end
  end

  localparam int SQ_END = 2 + SQRT_STEPS;

  side_a_t         sa_r [SQ_END+1];
  logic [SQW-1:0]  sq_r [4];
  logic [NW-1:0]   n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= SQ_END; k++) begin
        sa_r[k] <= '0;
      end
    end else begin
      sa_r[0] <= s1_nxt;
      for (int k = 1; k <= SQ_END; k++) begin
        sa_r[k] <= sa_r[k-1];
      end
    end
    for (int i = 0; i < 4; i++) begin
      sq_r[i] <= SQW'(sa_r[0].mag[i]) * SQW'(sa_r[0].mag[i]);
    end
    n_r <= NW'(sq_r[0]) + NW'(sq_r[1]) + NW'(sq_r[2]) + NW'(sq_r[3]);
  end

  logic [VW-1:0]    sv    [SQRT_STEPS+1];
  logic [REMW-1:0]  srem  [SQRT_STEPS+1];
  logic [ROOTW-1:0] sroot [SQRT_STEPS+1];

  assign sv[0]    = {n_r, 28'd0};
  assign srem[0]  = '0;
  assign sroot[0] = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    rmq_sqrt_cell u_cell (
      .clk    (clk),
      .v_i    (sv[k]),
      .rem_i  (srem[k]),
      .root_i (sroot[k]),
      .v_r    (sv[k+1]),
      .rem_r  (srem[k+1]),
      .root_r (sroot[k+1])
    );
  end

  side_a_t        s_at_root;
  logic [ROOTW-1:0] root;
  logic [NUMW-1:0]  num [4];

  always_comb begin
    s_at_root = sa_r[SQ_END];
    root      = sroot[SQRT_STEPS];
    for (int i = 0; i < 4; i++) begin
      num[i] = {s_at_root.mag[i], 29'd0} + NUMW'(root);
    end
  end

  logic [DW-1:0] dp   [4][DIV_STEPS+1];
  logic [QW-1:0] dlo  [4][DIV_STEPS+1];
  logic [DW-1:0] dd   [4][DIV_STEPS+1];
  logic [QW-1:0] dq   [4][DIV_STEPS+1];
  logic          dovf [4][DIV_STEPS+1];
  side_b_t       sb_r [DIV_STEPS+1];

  logic [DW-1:0] dp0_r   [4];
  logic [QW-1:0] dlo0_r  [4];
  logic [DW-1:0] dd0_r   [4];
  logic          dovf0_r [4];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      dp0_r[i]   <= DW'(num[i][NUMW-1:QW]);
      dlo0_r[i]  <= num[i][QW-1:0];
      dd0_r[i]   <= {root, 1'b0};
      dovf0_r[i] <= (NUMW'(num[i][NUMW-1:QW]) >= NUMW'({root, 1'b0}));
    end
    if (!rst_n) begin
      for (int k = 0; k <= DIV_STEPS; k++) begin
        sb_r[k] <= '0;
      end
    end else begin
      sb_r[0] <= '{valid: s_at_root.valid, deg: s_at_root.deg,
                   branch: s_at_root.branch, neg: s_at_root.neg};
      for (int k = 1; k <= DIV_STEPS; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    assign dp[i][0]   = dp0_r[i];
    assign dlo[i][0]  = dlo0_r[i];
    assign dd[i][0]   = dd0_r[i];
    assign dq[i][0]   = '0;
    assign dovf[i][0] = dovf0_r[i];
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      rmq_div_cell u_cell (
        .clk   (clk),
        .p_i   (dp[i][k]),
        .lo_i  (dlo[i][k]),
        .d_i   (dd[i][k]),
        .q_i   (dq[i][k]),
        .ovf_i (dovf[i][k]),
        .p_r   (dp[i][k+1]),
        .lo_r  (dlo[i][k+1]),
        .d_r   (dd[i][k+1]),
        .q_r   (dq[i][k+1]),
        .ovf_r (dovf[i][k+1])
      );
    end
  end

  side_b_t              s_end;
  logic [QW-1:0]        qs   [4];
  logic signed [MW-1:0] comp [4];

  always_comb begin
    s_end = sb_r[DIV_STEPS];
    for (int i = 0; i < 4; i++) begin
      qs[i] = (dovf[i][DIV_STEPS] || dq[i][DIV_STEPS] > UNIT_Q14) ? UNIT_Q14 : dq[i][DIV_STEPS];
      comp[i] = s_end.neg[i] ? -MW'(qs[i]) : MW'(qs[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s_end.valid;
    end
    out_branch_taken <= s_end.branch;
    out_degenerate   <= s_end.deg;
    if (s_end.deg) begin
      out_quat_x <= '0;
      out_quat_y <= '0;
      out_quat_z <= '0;
      out_quat_w <= MW'(UNIT_Q14);
    end else begin
      out_quat_x <= comp[0];
      out_quat_y <= comp[1];
      out_quat_z <= comp[2];
      out_quat_w <= comp[3];
    end
  end

endmodule
`default_nettype wire

>>> rtl/rmq_checker.sv
// Port-level checker for the rotation matrix to quaternion block, with its bind.
`default_nettype none
module rmq_checker import rmq_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 out_valid,
  input wire logic signed [MW-1:0] out_quat_x,
  input wire logic signed [MW-1:0] out_quat_y,
  input wire logic signed [MW-1:0] out_quat_z,
  input wire logic signed [MW-1:0] out_quat_w,
  input wire logic                 out_degenerate
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without a matching request");

  a_degenerate_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |-> (out_quat_x == 0 && out_quat_y == 0 &&
    out_quat_z == 0 && out_quat_w == 16'sd16384))
    else $error("degenerate result is not the identity");

  a_w_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_quat_w <= 16'sd16384 && out_quat_w >= -16'sd16384))
    else $error("scalar component out of range");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_quat_x     (out_quat_x),
  .out_quat_y     (out_quat_y),
  .out_quat_z     (out_quat_z),
  .out_quat_w     (out_quat_w),
  .out_degenerate (out_degenerate)
);
`default_nettype wire
